// ----- src/spve_pkg.sv -----
// ----------------------------------------------------------------------------
// spve_pkg
// Shared types, constants and the exponential table function for the
// split pseudo-Voigt evaluator.
// ----------------------------------------------------------------------------
package spve_pkg;

   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] LN2_Q30 = 64'd744261118;
   localparam logic [23:0] U16_MAX = 24'hFFFFFF;
   localparam logic [15:0] MIX_ONE = 16'd32768;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PEAK_CENTER     = 3'd0,
      CSR_PEAK_HEIGHT     = 3'd1,
      CSR_LEFT_HALFWIDTH  = 3'd2,
      CSR_RIGHT_HALFWIDTH = 3'd3,
      CSR_LEFT_MIX        = 3'd4,
      CSR_RIGHT_MIX       = 3'd5
   } csr_index_type;

   // e^(-z) in q.30, z in q.30, nested series up to the z^7 term
   function automatic logic [30:0] exp_q30(input logic [63:0] z);
      logic [63:0] h;
      logic [63:0] p;
      h = Q30_ONE;
      for (int j = 7; j >= 1; j--) begin
         p = (z * h) >> 30;
         h = Q30_ONE - (p / 64'(j));
      end
      return h[30:0];
   endfunction

endpackage

// ----- src/spve_divider.sv -----
// ----------------------------------------------------------------------------
// spve_divider
// Pipelined restoring divider, one quotient bit per register stage, with a
// per-transaction divisor and a sideband tag that travels alongside.
// ----------------------------------------------------------------------------
module spve_divider #(
   parameter int QW = 24,
   parameter int DW = 32,
   parameter int TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_bits,
   input  logic [DW-1:0] in_divisor,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [TW-1:0] out_tag
);

   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] nq_ff    [QW];
   logic [DW-1:0] div_ff   [QW];
   logic [TW-1:0] tag_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic          src_valid;
      logic [DW-1:0] src_rem;
      logic [QW-1:0] src_nq;
      logic [DW-1:0] src_div;
      logic [TW-1:0] src_tag;
      logic [DW:0]   rem2;
      logic [DW:0]   diff;
      logic          ge;
      logic [QW:0]   nq_wide;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] nq_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_rem;
         assign src_nq    = in_bits;
         assign src_div   = in_divisor;
         assign src_tag   = in_tag;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_nq    = nq_ff[i-1];
         assign src_div   = div_ff[i-1];
         assign src_tag   = tag_ff[i-1];
      end

      always_comb begin
         rem2    = {src_rem, src_nq[QW-1]};
         diff    = rem2 - {1'b0, src_div};
         ge      = (rem2 >= {1'b0, src_div});
         rem_in  = ge ? diff[DW-1:0] : rem2[DW-1:0];
         nq_wide = {src_nq, ge};
         nq_in   = nq_wide[QW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= src_valid;
         end
         if (enable) begin
            rem_ff[i] <= rem_in;
            nq_ff[i]  <= nq_in;
            div_ff[i] <= src_div;
            tag_ff[i] <= src_tag;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = nq_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

// ----- src/spve_gauss_lut.sv -----
// ----------------------------------------------------------------------------
// spve_gauss_lut
// Two pipeline stages: splits u^2 into integer and fraction parts, then reads
// the 2^(-f) table at the scaled fraction index.
// ----------------------------------------------------------------------------
module spve_gauss_lut #(
   parameter int EXP_LUT_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [47:0] in_s,
   input  logic [15:0] in_m,
   output logic        out_valid,
   output logic [30:0] out_h,
   output logic [15:0] out_k,
   output logic [47:0] out_s,
   output logic [15:0] out_m
);

   localparam int IW = $clog2(EXP_LUT_DEPTH);
   localparam int PW = 16 + IW;

   logic [30:0] exp_rom [EXP_LUT_DEPTH];

   for (genvar i = 0; i < EXP_LUT_DEPTH; i++) begin : g_rom
      localparam logic [63:0] Y = (64'(i) << 30) / EXP_LUT_DEPTH;
      localparam logic [63:0] Z = (Y * spve_pkg::LN2_Q30) >> 30;
      assign exp_rom[i] = spve_pkg::exp_q30(Z);
   end

   logic          valid_a_ff;
   logic [IW-1:0] idx_a_ff;
   logic [15:0]   k_a_ff;
   logic [47:0]   s_a_ff;
   logic [15:0]   m_a_ff;
   logic [PW-1:0] prod_in;

   logic          valid_b_ff;
   logic [30:0]   h_b_ff;
   logic [15:0]   k_b_ff;
   logic [47:0]   s_b_ff;
   logic [15:0]   m_b_ff;

   assign prod_in = PW'(in_s[31:16]) * PW'(EXP_LUT_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
      if (enable) begin
         idx_a_ff <= prod_in[PW-1:16];
         k_a_ff   <= in_s[47:32];
         s_a_ff   <= in_s;
         m_a_ff   <= in_m;
         h_b_ff   <= exp_rom[idx_a_ff];
         k_b_ff   <= k_a_ff;
         s_b_ff   <= s_a_ff;
         m_b_ff   <= m_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_h     = h_b_ff;
   assign out_k     = k_b_ff;
   assign out_s     = s_b_ff;
   assign out_m     = m_b_ff;

endmodule

// ----- src/split_pseudo_voigt_eval.sv -----
// ----------------------------------------------------------------------------
// split_pseudo_voigt_eval
// Split pseudo-Voigt peak evaluator: one profile value per abscissa, fully
// pipelined fixed-point datapath.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | req_abscissa  (s32 q16.16)
//   rsp     | out | rsp_valid/rsp_stall  | rsp_value     (u32 q16.16)
//   csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One transaction per cycle while the result is not stalled; the two bit-serial
// divider pipelines have 24 stages for u and 31 for the lorentzian.
// Reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module split_pseudo_voigt_eval #(
   parameter int EXP_LUT_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_abscissa,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [spve_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] center_ff, height_ff, lhw_ff, rhw_ff;
   logic [15:0] lmix_ff, rmix_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= 32'd0;
         height_ff <= 32'd65536;
         lhw_ff    <= 32'd65536;
         rhw_ff    <= 32'd65536;
         lmix_ff   <= 16'd0;
         rmix_ff   <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         case (spve_pkg::csr_index_type'(csr_index))
            spve_pkg::CSR_PEAK_CENTER:     center_ff <= csr_wdata;
            spve_pkg::CSR_PEAK_HEIGHT:     height_ff <= csr_wdata;
            spve_pkg::CSR_LEFT_HALFWIDTH:  lhw_ff    <= csr_wdata;
            spve_pkg::CSR_RIGHT_HALFWIDTH: rhw_ff    <= csr_wdata;
            spve_pkg::CSR_LEFT_MIX:        lmix_ff   <= csr_wdata[15:0];
            spve_pkg::CSR_RIGHT_MIX:       rmix_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   logic [31:0] rsp_value_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // stage 1: difference, side select
   logic        v1_ff;
   logic [32:0] ad1_ff;
   logic [31:0] w1_ff;
   logic [15:0] m1_ff;
   logic [32:0] d_in;
   logic [32:0] ad_in;
   logic        left_in;
   logic [31:0] w_sel, w_in;
   logic [15:0] m_sel, m_in;

   always_comb begin
      d_in    = {req_abscissa[31], req_abscissa} - {center_ff[31], center_ff};
      ad_in   = d_in[32] ? (33'd0 - d_in) : d_in;
      left_in = ($signed(req_abscissa) <= $signed(center_ff));
      w_sel   = left_in ? lhw_ff : rhw_ff;
      m_sel   = left_in ? lmix_ff : rmix_ff;
      w_in    = (w_sel == 32'd0) ? 32'd1 : w_sel;
      m_in    = (m_sel > spve_pkg::MIX_ONE) ? spve_pkg::MIX_ONE : m_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         ad1_ff <= ad_in;
         w1_ff  <= w_in;
         m1_ff  <= m_in;
      end
   end

   // u = |d| / w, saturated
   logic        sat1;
   logic        dv1_valid;
   logic [23:0] dv1_quot;
   logic [16:0] dv1_tag;

   assign sat1 = ({7'd0, ad1_ff} >= {w1_ff, 8'd0});

   spve_divider #(.QW(24), .DW(32), .TW(17)) u_div_u (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .in_valid   (v1_ff),
      .in_rem     (32'(ad1_ff[32:8])),
      .in_bits    ({ad1_ff[7:0], 16'd0}),
      .in_divisor (w1_ff),
      .in_tag     ({sat1, m1_ff}),
      .out_valid  (dv1_valid),
      .out_quot   (dv1_quot),
      .out_tag    (dv1_tag)
   );

   // stage 3: u^2
   logic        v3_ff;
   logic [47:0] s3_ff;
   logic [15:0] m3_ff;
   logic [23:0] u_in;

   assign u_in = dv1_tag[16] ? spve_pkg::U16_MAX : dv1_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= dv1_valid;
      end
      if (adv) begin
         s3_ff <= 48'(u_in) * 48'(u_in);
         m3_ff <= dv1_tag[15:0];
      end
   end

   logic        g5_valid;
   logic [30:0] h5;
   logic [15:0] k5;
   logic [47:0] s5;
   logic [15:0] m5;

   spve_gauss_lut #(.EXP_LUT_DEPTH(EXP_LUT_DEPTH)) u_gauss (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v3_ff),
      .in_s      (s3_ff),
      .in_m      (m3_ff),
      .out_valid (g5_valid),
      .out_h     (h5),
      .out_k     (k5),
      .out_s     (s5),
      .out_m     (m5)
   );

   // lorentzian 2^62 / (2^32 + s), gaussian term rides in the tag
   logic [30:0] g5;
   logic [48:0] lor_div;
   logic        dv2_valid;
   logic [30:0] dv2_quot;
   logic [46:0] dv2_tag;

   assign g5      = (k5 >= 16'd31) ? 31'd0 : (h5 >> k5[4:0]);
   assign lor_div = (49'd1 << 32) + 49'(s5);

   spve_divider #(.QW(31), .DW(49), .TW(47)) u_div_lor (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .in_valid   (g5_valid),
      .in_rem     (49'd1 << 31),
      .in_bits    (31'd0),
      .in_divisor (lor_div),
      .in_tag     ({g5, m5}),
      .out_valid  (dv2_valid),
      .out_quot   (dv2_quot),
      .out_tag    (dv2_tag)
   );

   // stages 6..8: blend and scale
   logic        v6_ff, v7_ff;
   logic [46:0] pg6_ff, pl6_ff;
   logic [30:0] shape7_ff;
   logic [46:0] sum_in;
   logic [62:0] prod_in;
   logic [15:0] gmix_in;

   assign gmix_in = spve_pkg::MIX_ONE - dv2_tag[15:0];
   assign sum_in  = pg6_ff + pl6_ff;
   assign prod_in = 63'(height_ff) * 63'(shape7_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v6_ff        <= dv2_valid;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
      if (adv) begin
         pg6_ff       <= 47'(gmix_in) * 47'(dv2_tag[46:16]);
         pl6_ff       <= 47'(dv2_tag[15:0]) * 47'(dv2_quot);
         shape7_ff    <= sum_in[45:15];
         rsp_value_ff <= prod_in[62] ? 32'hFFFFFFFF : prod_in[61:30];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_value_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff <= height_ff))
      else $error("result above peak height");

   a_mix_clamped: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (m1_ff <= spve_pkg::MIX_ONE))
      else $error("mix fraction not limited");

   a_shape_bounded: assert property (@(posedge clock) disable iff (reset)
      v7_ff |-> (shape7_ff <= 31'h40000000))
      else $error("shape above one");

   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      (!adv && v3_ff) |=> (v3_ff && $stable(s3_ff)))
      else $error("pipeline moved while stalled");
`endif

endmodule
